// ----- design/fcull_pkg.sv -----
// Shared types and constants for the frustum cull test block.
// No dependencies; fcull_if and frustum_cull_test refer to it by scoped names.
package fcull_pkg;

  localparam int NUM_PLANES     = 6;
  localparam int COEF_FRAC_BITS = 14;
  localparam int NEAR_PLANE     = 5;
  localparam int CFG_IDX_W      = 3;

  localparam logic [5:0] ALL_PLANES_MASK = 6'h3f;

  typedef enum logic [1:0] {
    OP_BOX    = 2'd0,
    OP_SPHERE = 2'd1,
    OP_NEAR   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  // packed plane word: a in bits 15:0, d in bits 63:48
  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] c;
    logic signed [15:0] b;
    logic signed [15:0] a;
  } plane_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] lo_x;
    logic signed [15:0] lo_y;
    logic signed [15:0] lo_z;
    logic signed [15:0] hi_x;
    logic signed [15:0] hi_y;
    logic signed [15:0] hi_z;
    logic [14:0]        radius;
    logic signed [15:0] dist_limit;
  } item_t;

endpackage

// ----- design/fcull_if.sv -----
// Channel interfaces of the frustum cull test block: config write, input and result.
// Uses fcull_pkg for the register index width.
interface fcull_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fcull_pkg::CFG_IDX_W-1:0]  index;
  logic [63:0]                      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface fcull_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] lo_x;
  logic signed [15:0] lo_y;
  logic signed [15:0] lo_z;
  logic signed [15:0] hi_x;
  logic signed [15:0] hi_y;
  logic signed [15:0] hi_z;
  logic [14:0]        radius;
  logic signed [15:0] dist_limit;
  modport source (output valid, output opcode, output lo_x, output lo_y, output lo_z,
                  output hi_x, output hi_y, output hi_z, output radius,
                  output dist_limit, input ready);
  modport sink   (input valid, input opcode, input lo_x, input lo_y, input lo_z,
                  input hi_x, input hi_y, input hi_z, input radius,
                  input dist_limit, output ready);
endinterface

interface fcull_out_if;
  logic       valid;
  logic       ready;
  logic       inside_res;
  logic [5:0] plane_mask;
  modport source (output valid, output inside_res, output plane_mask, input ready);
  modport sink   (input valid, input inside_res, input plane_mask, output ready);
endinterface

// ----- design/frustum_cull_test.sv -----
// Frustum cull test: box cull, sphere plane mask and near distance check.
// Three-stage pipeline (input register, product register, result register),
// one item per cycle while the receiver takes the results.
// The middle stage holds the 18 plane products; a stalled result does not
// block intake until all three stages are full.
// Synchronous active-low reset clears the planes to zero and empties the pipe.
module frustum_cull_test (
  input  logic           clk,
  input  logic           rst_n,
  fcull_cfg_if.sink      cfg_ch,
  fcull_in_if.sink       in_ch,
  fcull_out_if.source    out_ch
);

  localparam int NP = fcull_pkg::NUM_PLANES;
  localparam int FB = fcull_pkg::COEF_FRAC_BITS;

  fcull_pkg::plane_t  plane_r [NP];

  logic               s1_v_r;
  fcull_pkg::item_t   s1_r;
  logic               s2_v_r;
  fcull_pkg::op_t     s2_op_r;
  logic [14:0]        s2_rad_r;
  logic signed [15:0] s2_lim_r;
  logic signed [32:0] prod_r   [NP][3];
  logic signed [32:0] prod_nxt [NP][3];
  logic               out_v_r;
  logic               inside_r, inside_nxt;
  logic [5:0]         mask_r, mask_nxt;

  logic               ok1, ok2, ok3;

  logic signed [15:0] coef [NP][3];
  logic signed [15:0] lo   [3];
  logic signed [15:0] hi   [3];
  logic signed [16:0] opnd [NP][3];

  logic signed [34:0] sum_s   [NP];
  logic signed [34:0] shf_s   [NP];
  logic signed [35:0] dist_s  [NP];
  logic signed [36:0] marg_s  [NP];
  logic signed [15:0] rad_s;
  logic [5:0]         neg_v;
  logic [5:0]         front_v;
  logic               beyond;

  // config: writes past the last plane are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NP; i++) plane_r[i] <= '0;
    end else if (cfg_ch.valid &&
                 (cfg_ch.index < fcull_pkg::CFG_IDX_W'(NP))) begin
      plane_r[cfg_ch.index] <= fcull_pkg::plane_t'(cfg_ch.data);
    end
  end

  // pipeline flow control
  assign ok3 = !out_v_r || out_ch.ready;
  assign ok2 = !s2_v_r || ok3;
  assign ok1 = !s1_v_r || ok2;
  assign in_ch.ready = ok1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ok1) s1_v_r  <= in_ch.valid;
      if (ok2) s2_v_r  <= s1_v_r;
      if (ok3) out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ok1 && in_ch.valid) begin
      s1_r.op         <= fcull_pkg::op_t'(in_ch.opcode);
      s1_r.lo_x       <= in_ch.lo_x;
      s1_r.lo_y       <= in_ch.lo_y;
      s1_r.lo_z       <= in_ch.lo_z;
      s1_r.hi_x       <= in_ch.hi_x;
      s1_r.hi_y       <= in_ch.hi_y;
      s1_r.hi_z       <= in_ch.hi_z;
      s1_r.radius     <= in_ch.radius;
      s1_r.dist_limit <= in_ch.dist_limit;
    end
    if (ok2 && s1_v_r) begin
      s2_op_r  <= s1_r.op;
      s2_rad_r <= s1_r.radius;
      s2_lim_r <= s1_r.dist_limit;
      prod_r   <= prod_nxt;
    end
    if (ok3 && s2_v_r) begin
      inside_r <= inside_nxt;
      mask_r   <= mask_nxt;
    end
  end

  // stage 1: pick the point per plane and axis, then multiply
  always_comb begin
    lo[0] = s1_r.lo_x;  lo[1] = s1_r.lo_y;  lo[2] = s1_r.lo_z;
    hi[0] = s1_r.hi_x;  hi[1] = s1_r.hi_y;  hi[2] = s1_r.hi_z;
    for (int i = 0; i < NP; i++) begin
      coef[i][0] = plane_r[i].a;
      coef[i][1] = plane_r[i].b;
      coef[i][2] = plane_r[i].c;
      for (int k = 0; k < 3; k++) begin
        unique case (s1_r.op)
          fcull_pkg::OP_BOX: begin
            // corner farthest along the normal: larger coord for a positive coef
            if (coef[i][k][15] == (lo[k] > hi[k])) opnd[i][k] = 17'(hi[k]);
            else                                   opnd[i][k] = 17'(lo[k]);
          end
          fcull_pkg::OP_NEAR: opnd[i][k] = 17'(lo[k]) + 17'(hi[k]);
          default:            opnd[i][k] = 17'(lo[k]);
        endcase
        prod_nxt[i][k] = 33'(coef[i][k]) * 33'(opnd[i][k]);
      end
    end
  end

  // stage 2: sum, floor shift, offset and compare
  assign rad_s = $signed({1'b0, s2_rad_r});

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      sum_s[i] = 35'(prod_r[i][0]) + 35'(prod_r[i][1]) + 35'(prod_r[i][2]);
      // near check uses doubled center coords, so one more bit comes off
      if (s2_op_r == fcull_pkg::OP_NEAR) shf_s[i] = sum_s[i] >>> (FB + 1);
      else                               shf_s[i] = sum_s[i] >>> FB;
      dist_s[i]  = 36'(shf_s[i]) + 36'(plane_r[i].d);
      marg_s[i]  = 37'(dist_s[i]) + 37'(rad_s);
      neg_v[i]   = dist_s[i][35];
      front_v[i] = (marg_s[i] > 37'sd0);
    end
    beyond = dist_s[fcull_pkg::NEAR_PLANE] > 36'(s2_lim_r);

    unique case (s2_op_r)
      fcull_pkg::OP_BOX: begin
        inside_nxt = !(|neg_v);
        mask_nxt   = fcull_pkg::ALL_PLANES_MASK;
      end
      fcull_pkg::OP_SPHERE: begin
        inside_nxt = &front_v;
        mask_nxt   = front_v;
      end
      fcull_pkg::OP_NEAR: begin
        inside_nxt = beyond;
        mask_nxt   = fcull_pkg::ALL_PLANES_MASK;
      end
      default: begin
        inside_nxt = 1'b0;
        mask_nxt   = fcull_pkg::ALL_PLANES_MASK;
      end
    endcase
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.inside_res = inside_r;
  assign out_ch.plane_mask = mask_r;

endmodule

// ----- design/fcull_chk.sv -----
// Port-level checks for frustum_cull_test, attached by bind.
// Depends on the top level's channel interfaces.
module fcull_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       inside_res,
  input logic [5:0] plane_mask
);

  logic [2:0] occ_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(inside_res) && $stable(plane_mask))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (plane_mask != 6'h3f) |-> !inside_res)
    else $error("visible with a plane culled");

  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r <= 3'd3) && (!out_valid || (occ_r != 3'd0)))
    else $error("item count out of range");

endmodule

bind frustum_cull_test fcull_chk u_fcull_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .inside_res (out_ch.inside_res),
  .plane_mask (out_ch.plane_mask)
);

// ----- test/frustum_cull_test_tb.sv -----
// Self-checking testbench for frustum_cull_test: box cull, sphere mask and near check.
// Predicts each verdict from its own copy of the six planes; needs fcull_pkg and fcull_if.
// Random valid/ready gaps on both channels and one long result hold-off.
module frustum_cull_test_tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int ONE_Q14       = 16384;

  typedef struct {
    logic       visible;
    logic [5:0] mask;
  } verdict_t;

  logic clk;
  logic rst_n;

  fcull_cfg_if cfg_ch ();
  fcull_in_if  in_ch ();
  fcull_out_if out_ch ();

  frustum_cull_test DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [63:0] plane_words [fcull_pkg::NUM_PLANES];
  verdict_t    expected_verdicts [$];
  int          fails;
  bit          src_idle_en;
  bit          sink_idle_en;
  int          hold_asks;
  int          hold_seen;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- prediction
  function automatic longint plane_distance(input int p, input longint x, input longint y,
                                            input longint z, input int sh);
    fcull_pkg::plane_t pl;
    longint s;
    pl = plane_words[p];
    s = longint'(pl.a) * x + longint'(pl.b) * y + longint'(pl.c) * z;
    return (s >>> sh) + longint'(pl.d);
  endfunction

  function automatic verdict_t predict_verdict(input fcull_pkg::item_t it);
    verdict_t v;
    bit all_neg;
    longint x, y, z, dn;
    v.visible = 1'b0;
    v.mask = fcull_pkg::ALL_PLANES_MASK;
    case (it.op)
      fcull_pkg::OP_BOX: begin
        v.visible = 1'b1;
        for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
          all_neg = 1'b1;
          for (int k = 0; k < 8; k++) begin
            x = k[0] ? it.hi_x : it.lo_x;
            y = k[1] ? it.hi_y : it.lo_y;
            z = k[2] ? it.hi_z : it.lo_z;
            if (plane_distance(p, x, y, z, fcull_pkg::COEF_FRAC_BITS) >= 0) all_neg = 1'b0;
          end
          if (all_neg) v.visible = 1'b0;
        end
      end
      fcull_pkg::OP_SPHERE: begin
        for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
          if (plane_distance(p, it.lo_x, it.lo_y, it.lo_z, fcull_pkg::COEF_FRAC_BITS)
              <= -longint'(it.radius))
            v.mask[p] = 1'b0;
        end
        v.visible = (v.mask == fcull_pkg::ALL_PLANES_MASK);
      end
      fcull_pkg::OP_NEAR: begin
        // center kept with one extra fraction bit
        dn = plane_distance(fcull_pkg::NEAR_PLANE, longint'(it.lo_x) + longint'(it.hi_x),
                            longint'(it.lo_y) + longint'(it.hi_y),
                            longint'(it.lo_z) + longint'(it.hi_z),
                            fcull_pkg::COEF_FRAC_BITS + 1);
        v.visible = (dn > longint'(it.dist_limit));
      end
      default: v.visible = 1'b0;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic logic [63:0] pack_plane(input int a, input int b, input int c,
                                             input int d);
    logic [15:0] fa, fb, fc, fd;
    fa = 16'(a);
    fb = 16'(b);
    fc = 16'(c);
    fd = 16'(d);
    return {fd, fc, fb, fa};
  endfunction

  function automatic fcull_pkg::item_t mk_item(input fcull_pkg::op_t op, input int lx,
                                               input int ly, input int lz,
                                               input int hx, input int hy, input int hz,
                                               input int r, input int lim);
    fcull_pkg::item_t it;
    it.op = op;
    it.lo_x = 16'(lx);
    it.lo_y = 16'(ly);
    it.lo_z = 16'(lz);
    it.hi_x = 16'(hx);
    it.hi_y = 16'(hy);
    it.hi_z = 16'(hz);
    it.radius = 15'(r);
    it.dist_limit = 16'(lim);
    return it;
  endfunction

  function automatic void rand_span(output logic signed [15:0] lo,
                                    output logic signed [15:0] hi);
    int c, e;
    logic signed [15:0] t;
    if ($urandom_range(3) == 0) begin
      lo = 16'($urandom);
      hi = 16'($urandom);
    end else begin
      c = int'($urandom_range(6000)) - 3000;
      e = $urandom_range(400);
      lo = 16'(c - e);
      hi = 16'(c + e);
      if ($urandom_range(9) == 0) begin
        t = lo;
        lo = hi;
        hi = t;
      end
    end
  endfunction

  function automatic fcull_pkg::item_t rand_item();
    fcull_pkg::item_t it;
    int pick;
    pick = $urandom_range(99);
    it.op = (pick < 4) ? fcull_pkg::OP_RSVD : fcull_pkg::op_t'(pick % 3);
    rand_span(it.lo_x, it.hi_x);
    rand_span(it.lo_y, it.hi_y);
    rand_span(it.lo_z, it.hi_z);
    it.radius = $urandom_range(1) ? 15'($urandom) : 15'($urandom_range(600));
    it.dist_limit = $urandom_range(1) ? 16'($urandom) : 16'(int'($urandom_range(6000)) - 3000);
    return it;
  endfunction

  function automatic int corner_coef();
    case ($urandom_range(3))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 0;
      default: return 16'hffff;
    endcase
  endfunction

  // ---------------------------------------------------------------- channels
  task automatic write_plane(input logic [fcull_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] word);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= word;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx < fcull_pkg::NUM_PLANES) plane_words[idx] = word;
    @(posedge clk);
  endtask

  // leaves valid high on return so back-to-back items need no second assignment
  task automatic send_item(input fcull_pkg::item_t it);
    if (src_idle_en && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= it.op;
    in_ch.lo_x       <= it.lo_x;
    in_ch.lo_y       <= it.lo_y;
    in_ch.lo_z       <= it.lo_z;
    in_ch.hi_x       <= it.hi_x;
    in_ch.hi_y       <= it.hi_y;
    in_ch.hi_z       <= it.hi_z;
    in_ch.radius     <= it.radius;
    in_ch.dist_limit <= it.dist_limit;
    do @(posedge clk); while (!in_ch.ready);
    expected_verdicts.push_back(predict_verdict(it));
  endtask

  task automatic drain();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_seen = hold_asks;
      end else if (sink_idle_en && $urandom_range(99) < 14) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result item with no expectation: inside_res %0d plane_mask %0h",
               out_ch.inside_res, out_ch.plane_mask);
        fails++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (out_ch.inside_res !== exp_v.visible) begin
          $error("inside_res: expected %0d, got %0d", exp_v.visible, out_ch.inside_res);
          fails++;
        end
        if (out_ch.plane_mask !== exp_v.mask) begin
          $error("plane_mask: expected %0h, got %0h", exp_v.mask, out_ch.plane_mask);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- plane sets
  // axis-aligned cube, half width per face; plane 5 is the -z face
  task automatic load_cube(input int h0, input int h1, input int h2, input int h3,
                           input int h4, input int h5);
    write_plane(3'd0, pack_plane(ONE_Q14, 0, 0, h0));
    write_plane(3'd1, pack_plane(-16384, 0, 0, h1));
    write_plane(3'd2, pack_plane(0, ONE_Q14, 0, h2));
    write_plane(3'd3, pack_plane(0, -16384, 0, h3));
    write_plane(3'd4, pack_plane(0, 0, ONE_Q14, h4));
    write_plane(3'd5, pack_plane(0, 0, -16384, h5));
  endtask

  task automatic load_random_planes(input int kind);
    int a, b, c, d;
    for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
      case (kind)
        0: begin
          a = 0;
          b = 0;
          c = 0;
          d = int'($urandom_range(6000)) - 500;
          case (p)
            0: a = 16384;
            1: a = -16384;
            2: b = 16384;
            3: b = -16384;
            4: c = 16384;
            default: c = -16384;
          endcase
        end
        1: begin
          a = int'($urandom_range(32768)) - 16384;
          b = int'($urandom_range(32768)) - 16384;
          c = int'($urandom_range(32768)) - 16384;
          d = int'($urandom_range(8000)) - 4000;
        end
        2: begin
          a = $urandom;
          b = $urandom;
          c = $urandom;
          d = $urandom;
        end
        default: begin
          a = corner_coef();
          b = corner_coef();
          c = corner_coef();
          d = corner_coef();
        end
      endcase
      write_plane(3'(p), pack_plane(a, b, c, d));
    end
    // indexes past the last plane must be dropped
    if ($urandom_range(3) == 0) begin
      write_plane(3'($urandom_range(7, fcull_pkg::NUM_PLANES)), {$urandom, $urandom});
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_planes();
    // all planes zero: every distance is 0
    send_item(mk_item(fcull_pkg::OP_BOX, -5, -5, -5, 5, 5, 5, 0, 0));
    send_item(mk_item(fcull_pkg::OP_SPHERE, 100, 200, 300, 0, 0, 0, 0, 0));
    send_item(mk_item(fcull_pkg::OP_SPHERE, 100, 200, 300, 0, 0, 0, 1, 0));
    send_item(mk_item(fcull_pkg::OP_NEAR, 0, 0, 0, 0, 0, 0, 0, -1));
    send_item(mk_item(fcull_pkg::OP_RSVD, 7, 7, 7, 7, 7, 7, 7, 7));
    drain();
  endtask

  task automatic test_directed_cube();
    load_cube(1000, 1000, 1000, 1000, 1000, 1000);
    send_item(mk_item(fcull_pkg::OP_BOX, -10, -10, -10, 10, 10, 10, 0, 0));
    send_item(mk_item(fcull_pkg::OP_BOX, 2000, 0, 0, 3000, 10, 10, 0, 0));
    // corner lands exactly on the plane: kept
    send_item(mk_item(fcull_pkg::OP_BOX, 1000, 0, 0, 1500, 10, 10, 0, 0));
    // reversed boxes, used as given
    send_item(mk_item(fcull_pkg::OP_BOX, 3000, 0, 0, 2000, 10, 10, 0, 0));
    send_item(mk_item(fcull_pkg::OP_BOX, 500, 5, 5, -500, -5, -5, 0, 0));
    send_item(mk_item(fcull_pkg::OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0));
    send_item(mk_item(fcull_pkg::OP_BOX, -32768, -32768, -32768, -32768, -32768, -32768,
                      0, 0));
    send_item(mk_item(fcull_pkg::OP_BOX, 32767, 32767, 32767, 32767, 32767, 32767,
                      32767, 32767));
    send_item(mk_item(fcull_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(fcull_pkg::OP_SPHERE, 1500, 0, 0, 0, 0, 0, 500, 0));
    send_item(mk_item(fcull_pkg::OP_SPHERE, 1500, 0, 0, 0, 0, 0, 501, 0));
    send_item(mk_item(fcull_pkg::OP_SPHERE, 32767, -32768, 32767, 0, 0, 0, 32767, 0));
    send_item(mk_item(fcull_pkg::OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0, 0));
    send_item(mk_item(fcull_pkg::OP_NEAR, 0, 0, 0, 0, 0, 0, 0, 999));
    send_item(mk_item(fcull_pkg::OP_NEAR, 0, 0, 0, 0, 0, 0, 0, 1000));
    // half-unit center floors down
    send_item(mk_item(fcull_pkg::OP_NEAR, 0, 0, 0, 0, 0, 1, 0, 998));
    send_item(mk_item(fcull_pkg::OP_NEAR, 0, 0, 0, 0, 0, 1, 0, 999));
    send_item(mk_item(fcull_pkg::OP_NEAR, 32767, 32767, 32767, 32767, 32767, 32767,
                      0, -32768));
    send_item(mk_item(fcull_pkg::OP_NEAR, -32768, -32768, -32768, -32768, -32768, -32768,
                      0, 32767));
    send_item(mk_item(fcull_pkg::OP_RSVD, -32768, 32767, -32768, 32767, -32768, 32767,
                      32767, -32768));
    drain();
  endtask

  task automatic test_extreme_planes();
    logic [63:0] patterns [3];
    patterns[0] = 64'h7fff_7fff_7fff_7fff;
    patterns[1] = 64'h8000_8000_8000_8000;
    patterns[2] = 64'hffff_ffff_ffff_ffff;
    for (int s = 0; s < 3; s++) begin
      for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) write_plane(3'(p), patterns[s]);
      write_plane(3'd6, ~patterns[s]);
      write_plane(3'd7, {$urandom, $urandom});
      repeat (30) send_item(rand_item());
      drain();
    end
  endtask

  task automatic test_backpressure();
    load_cube(3000, 3000, 3000, 3000, 3000, 3000);
    src_idle_en = 1'b0;
    hold_asks++;
    repeat (40) send_item(rand_item());
    drain();
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_rounds();
    for (int round = 0; round < 8; round++) begin
      src_idle_en  = !(round == 2 || round == 5);
      sink_idle_en = src_idle_en;
      if (round < 4) load_random_planes(round);
      else load_random_planes($urandom_range(99) < 60 ? 0 : $urandom_range(3, 1));
      repeat (130) send_item(rand_item());
      drain();
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    fails = 0;
    hold_asks = 0;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.lo_x = '0;
    in_ch.lo_y = '0;
    in_ch.lo_z = '0;
    in_ch.hi_x = '0;
    in_ch.hi_y = '0;
    in_ch.hi_z = '0;
    in_ch.radius = '0;
    in_ch.dist_limit = '0;
    for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) plane_words[p] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_reset_planes();
    test_directed_cube();
    test_extreme_planes();
    test_backpressure();
    test_random_rounds();

    drain();
    if (expected_verdicts.size() != 0) begin
      $error("%0d expected result items never arrived", expected_verdicts.size());
      fails++;
    end
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/fcull_pkg.sv
design/fcull_if.sv
design/frustum_cull_test.sv
design/fcull_chk.sv
test/frustum_cull_test_tb.sv
